/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/utae_pkg.sv */
// Shared types, constants and character functions of the UTF-8 to ASCII escaper.
package utae_pkg;

    // Characters that the escaper emits on its own.
    localparam logic [6:0] CHAR_QMARK   = 7'h3F;
    localparam logic [6:0] CHAR_BSLASH  = 7'h5C;
    localparam logic [6:0] CHAR_LOWER_U = 7'h75;
    localparam logic [6:0] CHAR_UPPER_U = 7'h55;

    // Printable ASCII range.
    localparam logic [7:0] PRINT_LOW  = 8'h20;
    localparam logic [7:0] PRINT_HIGH = 8'h7E;

    // Code values at or above this limit take the long escape form.
    localparam logic [20:0] SHORT_LIMIT = 21'h00FFFF;

    // Character counts of the two escape forms.
    localparam logic [3:0] ESC_SHORT_LEN = 4'd6;
    localparam logic [3:0] ESC_LONG_LEN  = 4'd10;

    // Lengths of the multi-byte sequences.
    localparam logic [2:0] SEQ_LEN_2 = 3'd2;
    localparam logic [2:0] SEQ_LEN_3 = 3'd3;
    localparam logic [2:0] SEQ_LEN_4 = 3'd4;

    // Description of the characters that one input byte causes.
    typedef struct packed {
        logic [3:0]  count;      // number of characters, zero to ten
        logic        is_esc;     // backslash escape of a code value
        logic        long_form;  // eight hex digits instead of four
        logic [6:0]  ch;         // final character of a question mark run
        logic [20:0] value;      // code value of an escape
    } run_t;

    // Uppercase hex digit of a nibble.
    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] c;
        if (nib < 4'd10) begin
            c = 7'h30 + {3'b000, nib};
        end
        else begin
            c = 7'h37 + {3'b000, nib};
        end
        return c;
    endfunction

    // Character at position idx of a run.
    function automatic logic [6:0] char_at(input run_t run, input logic [3:0] idx);
        logic [3:0]  nib_sel;
        logic [31:0] wide;
        logic [3:0]  nib;
        logic [6:0]  c;
        wide = {11'b0, run.value};
        nib_sel = run.long_form ? (4'd9 - idx) : (4'd5 - idx);
        nib = wide[{nib_sel[2:0], 2'b00} +: 4];
        if (run.is_esc) begin
            if (idx == 4'd0) begin
                c = CHAR_BSLASH;
            end
            else if (idx == 4'd1) begin
                c = run.long_form ? CHAR_UPPER_U : CHAR_LOWER_U;
            end
            else begin
                c = hex_char(nib);
            end
        end
        else begin
            c = (idx == run.count - 4'd1) ? run.ch : CHAR_QMARK;
        end
        return c;
    endfunction

endpackage

/* hw/rtl/utae_ifs.sv */
// Valid/ready stream interfaces for the input bytes and the output characters.
interface utae_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface utae_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink (input valid, input out_char, input last_of_run, output ready);
endinterface

/* hw/rtl/utae_decode.sv */
// Input register, sequence state and byte decoder of the escaper.
module utae_decode (
    input  logic            clk,
    input  logic            rst_n,
    utae_in_if.sink         byte_in,
    input  logic            run_free,
    output logic            run_valid,
    output utae_pkg::run_t  run
);

    logic        item_valid_reg;
    logic [7:0]  byte_reg;
    logic        eot_reg;

    logic        in_seq_reg, in_seq_next;
    logic [2:0]  exp_len_reg, exp_len_next;
    logic [2:0]  coll_reg, coll_next;
    logic [20:0] acc_reg, acc_next;

    logic        advance;
    logic [6:0]  plain_char;

    // The held byte moves on when the emitter can take its run.
    assign advance      = item_valid_reg && run_free;
    assign byte_in.ready = !item_valid_reg || run_free;
    assign run_valid    = item_valid_reg;

    // Input register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (byte_in.ready)
        begin
            item_valid_reg <= byte_in.valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            byte_reg <= byte_in.in_byte;
            eot_reg  <= byte_in.end_of_text;
        end
    end

    // Printable bytes pass, everything else becomes a question mark.
    assign plain_char = (byte_reg >= utae_pkg::PRINT_LOW && byte_reg <= utae_pkg::PRINT_HIGH)
                        ? byte_reg[6:0] : utae_pkg::CHAR_QMARK;

    // Decode of one byte against the sequence state.
    always_comb
    begin
        in_seq_next  = in_seq_reg;
        exp_len_next = exp_len_reg;
        coll_next    = coll_reg;
        acc_next     = acc_reg;
        run          = '0;
        run.ch       = plain_char;
        if (in_seq_reg)
        begin
            if (byte_reg[7:6] == 2'b10)
            begin
                acc_next  = {acc_reg[14:0], byte_reg[5:0]};
                coll_next = coll_reg + 3'd1;
                if (coll_next >= exp_len_reg)
                begin
                    run.is_esc    = 1'b1;
                    run.long_form = (acc_next >= utae_pkg::SHORT_LIMIT);
                    run.count     = run.long_form ? utae_pkg::ESC_LONG_LEN
                                                  : utae_pkg::ESC_SHORT_LEN;
                    run.value     = acc_next;
                    in_seq_next   = 1'b0;
                    exp_len_next  = 3'd0;
                    coll_next     = 3'd0;
                    acc_next      = '0;
                end
            end
            else
            begin
                // One question mark per gathered byte, then the byte itself or a question mark if it is not printable.
                run.count    = {1'b0, coll_reg} + 4'd1;
                in_seq_next  = 1'b0;
                exp_len_next = 3'd0;
                coll_next    = 3'd0;
                acc_next     = '0;
            end
        end
        else if (!byte_reg[7])
        begin
            run.count = 4'd1;
        end
        else if (byte_reg[7:3] == 5'b11110)
        begin
            in_seq_next  = 1'b1;
            exp_len_next = utae_pkg::SEQ_LEN_4;
            coll_next    = 3'd1;
            acc_next     = {18'b0, byte_reg[2:0]};
        end
        else if (byte_reg[7:4] == 4'b1110)
        begin
            in_seq_next  = 1'b1;
            exp_len_next = utae_pkg::SEQ_LEN_3;
            coll_next    = 3'd1;
            acc_next     = {17'b0, byte_reg[3:0]};
        end
        else if (byte_reg[7:5] == 3'b110)
        begin
            in_seq_next  = 1'b1;
            exp_len_next = utae_pkg::SEQ_LEN_2;
            coll_next    = 3'd1;
            acc_next     = {16'b0, byte_reg[4:0]};
        end
        else
        begin
            run.count = 4'd1;
            run.ch    = utae_pkg::CHAR_QMARK;
        end
        // End of text drops any partial sequence.
        if (eot_reg)
        begin
            in_seq_next  = 1'b0;
            exp_len_next = 3'd0;
            coll_next    = 3'd0;
            acc_next     = '0;
        end
    end

    // Sequence state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_seq_reg  <= 1'b0;
            exp_len_reg <= 3'd0;
            coll_reg    <= 3'd0;
            acc_reg     <= '0;
        end
        else if (advance)
        begin
            in_seq_reg  <= in_seq_next;
            exp_len_reg <= exp_len_next;
            coll_reg    <= coll_next;
            acc_reg     <= acc_next;
        end
    end

endmodule

/* hw/rtl/utae_emit.sv */
// Run register and character serializer with the output register.
module utae_emit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            dec_valid,
    input  utae_pkg::run_t  dec_run,
    output logic            run_free,
    utae_out_if.source      char_out
);

    logic            run_valid_reg;
    utae_pkg::run_t  run_reg;
    logic [3:0]      idx_reg;
    logic            out_valid_reg;
    logic [6:0]      out_char_reg;
    logic            out_last_reg;

    logic            out_free;
    logic            load;
    logic            last_idx;
    logic            run_done;

    // One character a cycle into the output register, while the output is not stalled.
    assign out_free = !out_valid_reg || char_out.ready;
    assign load     = run_valid_reg && (run_reg.count != 4'd0) && out_free;
    assign last_idx = (idx_reg == run_reg.count - 4'd1);
    assign run_done = run_valid_reg && ((run_reg.count == 4'd0) || (load && last_idx));
    assign run_free = !run_valid_reg || run_done;

    // Run register control and character position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_valid_reg <= 1'b0;
            idx_reg       <= 4'd0;
        end
        else if (run_free)
        begin
            run_valid_reg <= dec_valid;
            idx_reg       <= 4'd0;
        end
        else if (load)
        begin
            idx_reg <= idx_reg + 4'd1;
        end
    end

    // Run register payload.
    always_ff @(posedge clk)
    begin
        if (run_free && dec_valid)
        begin
            run_reg <= dec_run;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (char_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg <= utae_pkg::char_at(run_reg, idx_reg);
            out_last_reg <= last_idx;
        end
    end

    assign char_out.valid       = out_valid_reg;
    assign char_out.out_char    = out_char_reg;
    assign char_out.last_of_run = out_last_reg;

endmodule

/* hw/rtl/utf8_to_ascii_escape_core.sv */
// Top level of the UTF-8 to 7-bit ASCII escaper.
// The block takes one text byte per transfer and gives 7-bit ASCII characters, one per
// transfer, with last_of_run set on the last character that a byte causes. A byte moves
// from the input register through the decoder into the run register, and the serializer
// then sends one character per cycle through the output register while the output is not
// stalled; the next byte waits in the input register until the run register is free. A byte
// causes 0 characters for a lead byte or a continuation inside a sequence, 1 for plain ASCII
// or a bad byte, 2 to 4 for a broken sequence, 6 or 10 for an escape. The single output register
// sets that rate. A byte passes the input register, the run register and the output register.
module utf8_to_ascii_escape_core (
    input  logic        clk,
    input  logic        rst_n,
    utae_in_if.sink     byte_in,
    utae_out_if.source  char_out
);

    logic            run_valid;
    logic            run_free;
    utae_pkg::run_t  run;

    // Byte decoder and sequence state.
    utae_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in),
        .run_free  (run_free),
        .run_valid (run_valid),
        .run       (run)
    );

    // Character serializer.
    utae_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .dec_valid (run_valid),
        .dec_run   (run),
        .run_free  (run_free),
        .char_out  (char_out)
    );

endmodule

/* hw/rtl/utae_checker.sv */
// Port-level checker of the escaper and its bind to the top level.
`include "assert_macros.svh"

module utae_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] out_char,
    input logic       out_last
);

    logic       out_xfer;
    logic       is_hex;
    logic       inner_ok;
    logic       is_u;
    logic [3:0] run_len_reg;
    logic       first_reg;
    logic       esc_pend_reg;

    assign out_xfer = out_valid && out_ready;
    assign is_hex   = (out_char >= 7'h30 && out_char <= 7'h39)
                   || (out_char >= 7'h41 && out_char <= 7'h46);
    assign is_u     = (out_char == utae_pkg::CHAR_LOWER_U)
                   || (out_char == utae_pkg::CHAR_UPPER_U);
    assign inner_ok = (out_char == utae_pkg::CHAR_QMARK)
                   || (out_char == utae_pkg::CHAR_BSLASH) || is_u || is_hex;

    // Track run length and escape openings over output transfers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_len_reg  <= 4'd0;
            first_reg    <= 1'b1;
            esc_pend_reg <= 1'b0;
        end
        else if (out_xfer)
        begin
            run_len_reg  <= out_last ? 4'd0 : run_len_reg + 4'd1;
            first_reg    <= out_last;
            esc_pend_reg <= first_reg && !out_last && (out_char == utae_pkg::CHAR_BSLASH);
        end
    end

    // A stalled character holds.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(out_last), "stalled output character changed")

    // No byte causes more than ten characters.
    `ASSERT_IMPLIES(a_run_len, clk, rst_n, out_xfer && !out_last, run_len_reg < 4'd9, "character run longer than ten")

    // Only question marks and escape characters precede the last of a run.
    `ASSERT_IMPLIES(a_inner_char, clk, rst_n, out_xfer && !out_last, inner_ok, "unexpected character inside a run")

    // An opening backslash is followed by the escape letter.
    `ASSERT_IMPLIES(a_esc_letter, clk, rst_n, out_xfer && esc_pend_reg, is_u && !out_last, "escape without u or U")

    // Input handshake signals come in through the bind but take part in no check.
    logic unused_in;
    assign unused_in = in_valid & in_ready;

endmodule

bind utf8_to_ascii_escape_core utae_checker u_utae_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (byte_in.valid),
    .in_ready  (byte_in.ready),
    .out_valid (char_out.valid),
    .out_ready (char_out.ready),
    .out_char  (char_out.out_char),
    .out_last  (char_out.last_of_run)
);
